>>> rtl/core/rxyp_pkg.sv
package rxyp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_QUOTE  = 3'd1,
    PH_KEY    = 3'd2,
    PH_CLOSE  = 3'd3,
    PH_SIGN   = 3'd4,
    PH_DIGITS = 3'd5,
    PH_DONE   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    BR_WAIT = 2'd0,
    BR_OK   = 2'd1,
    BR_BAD  = 2'd2
  } brace_e;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_EOL   = 2'd2,
    CMD_OVER  = 2'd3
  } cmd_e;

  localparam logic [19:0] AccCap   = 20'd1000001;
  localparam logic [19:0] AccLimit = 20'd1000000;
  localparam logic [0:0]  OpTick   = 1'b1;
  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] RegTimeout = '0;
  localparam logic [15:0] TimeoutReset = 16'd500;

  // classified item handed from front to back
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic signed [7:0] x_value;
    logic signed [7:0] y_value;
    logic              link_online;
    logic              frame_accepted;
    logic              frame_rejected;
    logic [31:0]       frame_total;
    logic [31:0]       error_total;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

>>> rtl/core/rxyp_key_match.sv
module rxyp_key_match (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             clear_i,
  input  logic [7:0]       ch_i,
  input  logic [7:0]       key_i,
  output logic             found_o,
  output logic             neg_o,
  output logic [19:0]      acc_o
);
  import rxyp_pkg::*;

  phase_e      ph_q, ph_d;
  logic        neg_q, neg_d;
  logic [19:0] acc_q, acc_d;
  logic [23:0] prod;
  logic        dig;
  logic        accum;
  logic        quote;

  always_comb begin
    dig   = is_digit(ch_i);
    quote = (ch_i == 8'h22);
    prod  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {20'd0, 4'(ch_i - 8'h30)};
    ph_d  = ph_q;
    neg_d = neg_q;
    acc_d = acc_q;
    accum = 1'b0;
    unique case (ph_q)
      PH_IDLE:  ph_d = quote ? PH_QUOTE : PH_IDLE;
      PH_QUOTE: ph_d = (ch_i == key_i) ? PH_KEY : (quote ? PH_QUOTE : PH_IDLE);
      PH_KEY:   ph_d = quote ? PH_CLOSE : PH_IDLE;
      PH_CLOSE: begin
        if (!is_blank(ch_i)) begin
          ph_d = (ch_i == 8'h3a) ? PH_SIGN : (quote ? PH_QUOTE : PH_IDLE);
        end
      end
      PH_SIGN: begin
        if (!is_blank(ch_i)) begin
          if (ch_i == 8'h2b || ch_i == 8'h2d) begin
            neg_d = (ch_i == 8'h2d);
            ph_d  = PH_DIGITS;
          end else if (!dig) begin
            ph_d = PH_DONE;
          end else begin
            ph_d  = PH_DIGITS;
            accum = 1'b1;
          end
        end
      end
      PH_DIGITS: begin
        if (!dig) ph_d = PH_DONE;
        else accum = 1'b1;
      end
      default: ph_d = PH_DONE;
    endcase
    if (accum) begin
      if (prod > {4'd0, AccLimit}) begin
        acc_d = AccCap;
        ph_d  = PH_DONE;
      end else begin
        acc_d = prod[19:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_IDLE;
      neg_q <= 1'b0;
      acc_q <= '0;
    end else if (clear_i) begin
      ph_q  <= PH_IDLE;
      neg_q <= 1'b0;
      acc_q <= '0;
    end else if (step_i) begin
      ph_q  <= ph_d;
      neg_q <= neg_d;
      acc_q <= acc_d;
    end
  end

  assign found_o = (ph_q >= PH_SIGN);
  assign neg_o   = neg_q;
  assign acc_o   = acc_q;

endmodule

>>> rtl/core/rxyp_front.sv
module rxyp_front #(
  parameter int unsigned LineMax = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          operation_i,
  input  logic [7:0]    byte_value_i,
  output logic          cmd_valid_o,
  input  logic          cmd_stall_i,
  output rxyp_pkg::cmd_t cmd_o
);
  import rxyp_pkg::*;

  localparam int unsigned LenW = $clog2(LineMax);
  localparam logic [LenW-1:0] LenMax = LenW'(LineMax - 1);

  logic [LenW-1:0] len_q, len_d;
  logic            vld_q;
  cmd_t            cmd_q, cmd_d;
  logic            take;

  assign in_stall_o = vld_q && cmd_stall_i;
  assign take       = in_valid_i && !in_stall_o;

  // line length is tracked here so overflow is known before the back end
  always_comb begin
    len_d = len_q;
    cmd_d.ch = byte_value_i;
    if (operation_i == OpTick) begin
      cmd_d.cmd = CMD_TICK;
    end else if (byte_value_i == 8'h0a || byte_value_i == 8'h0d) begin
      cmd_d.cmd = CMD_EOL;
      len_d     = '0;
    end else if (len_q < LenMax) begin
      cmd_d.cmd = CMD_CHAR;
      len_d     = len_q + 1'b1;
    end else begin
      cmd_d.cmd = CMD_OVER;
      len_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      vld_q <= 1'b0;
    end else begin
      if (take) begin
        len_q <= len_d;
        vld_q <= 1'b1;
      end else if (!cmd_stall_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_d;
  end

  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

endmodule

>>> rtl/core/rxyp_back.sv
module rxyp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      timeout_i,
  input  logic             cmd_valid_i,
  output logic             cmd_stall_o,
  input  rxyp_pkg::cmd_t   cmd_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rxyp_pkg::result_t res_o
);
  import rxyp_pkg::*;

  brace_e      brace_q, brace_d;
  logic        ended_q;
  logic        has_len_q;
  logic signed [7:0] hx_q, hy_q, cx, cy;
  logic        online_q;
  logic [31:0] elapsed_q, elapsed_inc;
  logic [31:0] frames_q, errors_q;
  logic        ovld_q;
  result_t     res_q;
  logic        go, eol, chr, over, ended_now, step, clr, good;
  logic        xf, yf, xn, yn;
  logic [19:0] xa, ya;
  logic        acc_hit, rej_hit;

  assign cmd_stall_o = ovld_q && out_stall_i;
  assign go          = cmd_valid_i && !cmd_stall_o;
  assign eol         = go && cmd_i.cmd == CMD_EOL;
  assign chr         = go && cmd_i.cmd == CMD_CHAR;
  assign over        = go && cmd_i.cmd == CMD_OVER;
  assign ended_now   = ended_q || (cmd_i.ch == 8'h00);
  assign step        = chr && !ended_now;
  assign clr         = over || (eol && has_len_q);
  assign good        = (brace_q == BR_OK) && xf && yf;
  assign acc_hit     = eol && has_len_q && good;
  assign rej_hit     = over || (eol && has_len_q && !good);

  rxyp_key_match u_x (
    .clk_i, .rst_ni, .step_i(step), .clear_i(clr), .ch_i(cmd_i.ch),
    .key_i(8'h78), .found_o(xf), .neg_o(xn), .acc_o(xa)
  );
  rxyp_key_match u_y (
    .clk_i, .rst_ni, .step_i(step), .clear_i(clr), .ch_i(cmd_i.ch),
    .key_i(8'h79), .found_o(yf), .neg_o(yn), .acc_o(ya)
  );

  function automatic logic signed [7:0] clamp(input logic n, input logic [19:0] a);
    logic [7:0] m;
    m = (a > 20'd100) ? 8'd100 : a[7:0];
    return n ? -$signed(m) : $signed(m);
  endfunction

  always_comb begin
    cx = clamp(xn, xa);
    cy = clamp(yn, ya);
    elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
    brace_d = brace_q;
    if (brace_q == BR_WAIT) begin
      if (ended_now) brace_d = BR_BAD;
      else if (!is_blank(cmd_i.ch)) brace_d = (cmd_i.ch == 8'h7b) ? BR_OK : BR_BAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brace_q   <= BR_WAIT;
      ended_q   <= 1'b0;
      has_len_q <= 1'b0;
      hx_q      <= '0;
      hy_q      <= '0;
      online_q  <= 1'b0;
      elapsed_q <= '0;
      frames_q  <= '0;
      errors_q  <= '0;
      ovld_q    <= 1'b0;
    end else begin
      if (go) begin
        ovld_q <= 1'b1;
        if (cmd_i.cmd == CMD_TICK) begin
          elapsed_q <= elapsed_inc;
          if (elapsed_inc > {16'd0, timeout_i}) online_q <= 1'b0;
        end
        if (chr) begin
          has_len_q <= 1'b1;
          ended_q   <= ended_now;
          brace_q   <= brace_d;
        end
        if (clr) begin
          has_len_q <= 1'b0;
          ended_q   <= 1'b0;
          brace_q   <= BR_WAIT;
        end
        if (acc_hit) begin
          hx_q      <= cx;
          hy_q      <= cy;
          elapsed_q <= '0;
          frames_q  <= frames_q + 32'd1;
          online_q  <= 1'b1;
        end
        if (rej_hit) errors_q <= errors_q + 32'd1;
      end else if (!out_stall_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      res_q.x_value        <= acc_hit ? cx : hx_q;
      res_q.y_value        <= acc_hit ? cy : hy_q;
      res_q.link_online    <= acc_hit ? 1'b1 :
          ((cmd_i.cmd == CMD_TICK && elapsed_inc > {16'd0, timeout_i}) ? 1'b0 : online_q);
      res_q.frame_accepted <= acc_hit;
      res_q.frame_rejected <= rej_hit;
      res_q.frame_total    <= acc_hit ? frames_q + 32'd1 : frames_q;
      res_q.error_total    <= rej_hit ? errors_q + 32'd1 : errors_q;
    end
  end

  assign out_valid_o = ovld_q;
  assign res_o       = res_q;

endmodule

>>> rtl/core/remote_xy_line_parser.sv
// Streaming parser for remote-control text lines. Each transaction is either a
// received byte or a 1 ms tick and gives exactly one result transaction. The
// block takes one item per clock unless stalled; a front stage classifies the
// item and tracks line length, a back stage runs both key matchers and the
// counters; each stage ends in a one-entry register. A line is valid when its
// first non-blank character is an open brace and it holds "x" and "y" keys,
// each followed by a colon; signed decimals clamp to -100..100. link_timeout_ms
// lies at address 0 and should be written only while the block is idle.
module remote_xy_line_parser #(
  parameter int unsigned LineMax = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [7:0]        byte_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [7:0] x_value_o,
  output logic signed [7:0] y_value_o,
  output logic              link_online_o,
  output logic              frame_accepted_o,
  output logic              frame_rejected_o,
  output logic [31:0]       frame_total_o,
  output logic [31:0]       error_total_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [rxyp_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import rxyp_pkg::*;

  logic [15:0] timeout_q;
  logic        cmd_valid, cmd_stall;
  cmd_t        cmd;
  result_t     res;

  assign pready = 1'b1;
  assign prdata = (paddr == RegTimeout) ? {16'd0, timeout_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (psel && penable && pwrite && paddr == RegTimeout) begin
      timeout_q <= pwdata[15:0];
    end
  end

  rxyp_front #(.LineMax(LineMax)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i, .byte_value_i,
    .cmd_valid_o(cmd_valid), .cmd_stall_i(cmd_stall), .cmd_o(cmd)
  );

  rxyp_back u_back (
    .clk_i, .rst_ni, .timeout_i(timeout_q), .cmd_valid_i(cmd_valid),
    .cmd_stall_o(cmd_stall), .cmd_i(cmd), .out_valid_o, .out_stall_i, .res_o(res)
  );

  assign x_value_o        = res.x_value;
  assign y_value_o        = res.y_value;
  assign link_online_o    = res.link_online;
  assign frame_accepted_o = res.frame_accepted;
  assign frame_rejected_o = res.frame_rejected;
  assign frame_total_o    = res.frame_total;
  assign error_total_o    = res.error_total;

endmodule

>>> rtl/core/rxyp_checker.sv
module rxyp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        frame_accepted_o,
  input logic        frame_rejected_o,
  input logic        link_online_o,
  input logic [31:0] frame_total_o
);

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(frame_accepted_o && frame_rejected_o))
    else $error("accept and reject together");

  a_online: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_accepted_o) |-> link_online_o)
    else $error("accepted frame not online");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(frame_total_o))
    else $error("stalled result changed");

endmodule

bind remote_xy_line_parser rxyp_checker u_rxyp_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .frame_accepted_o,
  .frame_rejected_o, .link_online_o, .frame_total_o
);
